// ----- src/binary_to_decimal_ascii_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII core
// Shorthand for clocked concurrent assertions used inside the RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Checked on every rising clock edge while the block is out of reset.
`define B2DA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define B2DA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/b2da_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Widths, pipeline types and the conversion steps shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

  localparam int VALUE_W   = 16;
  localparam int DIGITS    = 5;
  localparam int CHAR_W    = 6;
  localparam int COUNT_W   = 3;
  localparam int DD_STAGES = 4;
  localparam int ITERS_PER_STAGE = VALUE_W / DD_STAGES;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Double-dabble working state: BCD digits on top, remaining binary below.
  typedef struct packed {
    logic [DIGITS-1:0][3:0] bcd;
    logic [VALUE_W-1:0]     bin;
  } dd_state_t;

  // Formatted result; chars[0] is the most significant character.
  typedef struct packed {
    logic [DIGITS-1:0][CHAR_W-1:0] chars;
    logic [COUNT_W-1:0]            count;
  } result_t;

  // One shift-add-3 step.
  function automatic dd_state_t dd_iter(input dd_state_t s);
    dd_state_t r;
    r = s;
    for (int d = 0; d < DIGITS; d++) begin
      if (r.bcd[d] >= 4'd5) begin
        r.bcd[d] = r.bcd[d] + 4'd3;
      end
    end
    r = r << 1;
    return r;
  endfunction

  // Digit count and left-justified ASCII text from the finished BCD digits.
  function automatic result_t format_text(input logic [DIGITS-1:0][3:0] bcd);
    result_t            r;
    logic [COUNT_W-1:0] idx;
    priority if (bcd[4] != 4'd0) begin
      r.count = 3'd5;
    end else if (bcd[3] != 4'd0) begin
      r.count = 3'd4;
    end else if (bcd[2] != 4'd0) begin
      r.count = 3'd3;
    end else if (bcd[1] != 4'd0) begin
      r.count = 3'd2;
    end else begin
      r.count = 3'd1;
    end
    for (int k = 0; k < DIGITS; k++) begin
      idx = r.count - 3'd1 - COUNT_W'(k);
      if (COUNT_W'(k) < r.count) begin
        r.chars[k] = {2'b00, bcd[idx]} + ASCII_ZERO;
      end else begin
        r.chars[k] = '0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/binary_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// Binary to decimal ASCII core
// Converts an unsigned 16-bit value to left-justified decimal ASCII text.
// ----------------------------------------------------------------------------
// Each input transaction carries one unsigned 16-bit value and produces exactly
// one output transaction with the decimal text, most significant digit first
// and without leading zeros, plus the digit count from 1 to 5. Zero gives the
// single character '0'. Character ports past the digit count read as zero.
// The block takes a new transaction every clock cycle while in_stall_o is low.
// There are five register stages: four double-dabble stages of four
// shift-add-3 steps each, then one formatting stage that counts digits and
// builds the characters. The first stage loads at the edge that accepts the
// input; the value then moves through the later stages. Each stage advances
// whenever the stage after it is empty or moving, so bubbles close up and
// in_stall_o only rises once the whole pipeline is full and the output is
// stalled. There is no configuration and no state beyond the pipeline itself.
`timescale 1ns / 1ps
`default_nettype none

`include "binary_to_decimal_ascii_core_macros.svh"

module binary_to_decimal_ascii_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [b2da_pkg::VALUE_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [b2da_pkg::CHAR_W-1:0]        char_first_o,
  output logic [b2da_pkg::CHAR_W-1:0]        char_second_o,
  output logic [b2da_pkg::CHAR_W-1:0]        char_third_o,
  output logic [b2da_pkg::CHAR_W-1:0]        char_fourth_o,
  output logic [b2da_pkg::CHAR_W-1:0]        char_fifth_o,
  output logic [b2da_pkg::COUNT_W-1:0]       digit_count_o
);
  import b2da_pkg::*;

  // Conversion stages.
  dd_state_t                state_q [DD_STAGES];
  dd_state_t                state_d [DD_STAGES];
  logic [DD_STAGES-1:0]     valid_q;
  logic [DD_STAGES-1:0]     prev_valid;

  // Output stage.
  result_t                  res_q;
  logic                     out_valid_q;

  // ready[s] means stage s may load this cycle; the last entry is the output.
  logic [DD_STAGES:0]       ready;

  // A stage can load when it is empty or when its content moves on.
  always_comb begin
    ready[DD_STAGES] = !out_valid_q || !out_stall_i;
    for (int s = DD_STAGES - 1; s >= 0; s--) begin
      ready[s] = !valid_q[s] || ready[s+1];
    end
  end

  assign in_stall_o = !ready[0];

  // Each stage performs its share of the shift-add-3 steps on the input value
  // (first stage) or on the state held by the stage before it.
  always_comb begin
    dd_state_t cur;
    for (int s = 0; s < DD_STAGES; s++) begin
      if (s == 0) begin
        cur.bcd       = '0;
        cur.bin       = value_i;
        prev_valid[s] = in_valid_i;
      end else begin
        cur           = state_q[s-1];
        prev_valid[s] = valid_q[s-1];
      end
      for (int i = 0; i < ITERS_PER_STAGE; i++) begin
        cur = dd_iter(cur);
      end
      state_d[s] = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      for (int s = 0; s < DD_STAGES; s++) begin
        if (ready[s]) begin
          valid_q[s] <= prev_valid[s];
        end
      end
      if (ready[DD_STAGES]) begin
        out_valid_q <= valid_q[DD_STAGES-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DD_STAGES; s++) begin
      if (ready[s] && prev_valid[s]) begin
        state_q[s] <= state_d[s];
      end
    end
    if (ready[DD_STAGES] && valid_q[DD_STAGES-1]) begin
      res_q <= format_text(state_q[DD_STAGES-1].bcd);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_first_o  = res_q.chars[0];
  assign char_second_o = res_q.chars[1];
  assign char_third_o  = res_q.chars[2];
  assign char_fourth_o = res_q.chars[3];
  assign char_fifth_o  = res_q.chars[4];
  assign digit_count_o = res_q.count;

  // An accepted transaction always lands in the first stage.
  `B2DA_ASSERT(a_accept_lands, in_valid_i && !in_stall_o |=> valid_q[0], "accepted transaction lost")

  // After all shift steps every BCD digit is a valid decimal digit.
  `B2DA_ASSERT(a_bcd_digits, valid_q[DD_STAGES-1] |-> state_q[DD_STAGES-1].bcd[0] <= 4'd9 && state_q[DD_STAGES-1].bcd[1] <= 4'd9 && state_q[DD_STAGES-1].bcd[2] <= 4'd9 && state_q[DD_STAGES-1].bcd[3] <= 4'd9 && state_q[DD_STAGES-1].bcd[4] <= 4'd9, "BCD digit out of range")

  // A multi-digit result never starts with a zero character.
  `B2DA_ASSERT(a_no_lead_zero, out_valid_o && digit_count_o != 3'd1 |-> char_first_o != ASCII_ZERO, "leading zero in text")

  // The last character is blank whenever the text is shorter than five digits.
  `B2DA_ASSERT(a_fifth_blank, out_valid_o && digit_count_o != 3'd5 |-> char_fifth_o == '0, "character past digit count")

  // No result is presented while reset is held.
  `B2DA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

`default_nettype wire

// ----- tb/tb_binary_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// Testbench for the binary to decimal ASCII core
// Drives 16-bit values through the valid/stall input channel, predicts the
// left-justified decimal text and digit count of each one, and checks every
// output transaction in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_core;

  import b2da_pkg::*;

  // The five characters, most significant first, plus the digit count. The
  // value that produced them travels along so that reports can name it.
  typedef struct packed {
    logic [VALUE_W-1:0]           value;
    logic [4:0][CHAR_W-1:0]       text;
    logic [COUNT_W-1:0]           count;
  } decimal_text_t;

  localparam int NUM_RANDOM   = 1630;
  localparam int MAX_PRINTED  = 20;
  localparam int DRAIN_CYCLES = 12;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [VALUE_W-1:0]   value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CHAR_W-1:0]    char_first_o;
  logic [CHAR_W-1:0]    char_second_o;
  logic [CHAR_W-1:0]    char_third_o;
  logic [CHAR_W-1:0]    char_fourth_o;
  logic [CHAR_W-1:0]    char_fifth_o;
  logic [COUNT_W-1:0]   digit_count_o;

  // Values still to be offered, and the texts expected back, oldest first.
  logic [VALUE_W-1:0]   value_q[$];
  decimal_text_t        text_q[$];

  // Set at a rising edge when the input transaction on the bus was taken.
  logic                 in_taken;

  int unsigned          error_cnt;
  int unsigned          checked_cnt;
  int unsigned          count_seen[1:5];

  // Sender burst shaping and receiver stall pattern.
  int unsigned          burst_left;
  int unsigned          gap_left;
  int unsigned          stall_mode;
  int unsigned          stall_phase;

  binary_to_decimal_ascii_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_first_o  (char_first_o),
    .char_second_o (char_second_o),
    .char_third_o  (char_third_o),
    .char_fourth_o (char_fourth_o),
    .char_fifth_o  (char_fifth_o),
    .digit_count_o (digit_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Decimal text of a value: digit count from the decade it falls in, then
  // the digits peeled off from the least significant end into their
  // left-justified positions. Positions past the count stay zero.
  function automatic decimal_text_t decimal_text(input logic [VALUE_W-1:0] value);
    decimal_text_t r;
    int unsigned   n;
    int unsigned   len;
    r.value = value;
    r.text  = '0;
    n       = value;
    if (n < 10) begin
      len = 1;
    end else if (n < 100) begin
      len = 2;
    end else if (n < 1000) begin
      len = 3;
    end else if (n < 10000) begin
      len = 4;
    end else begin
      len = 5;
    end
    for (int k = int'(len) - 1; k >= 0; k--) begin
      r.text[k] = CHAR_W'((n % 10) + int'(ASCII_ZERO));
      n = n / 10;
    end
    r.count = COUNT_W'(len);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want,
                                 input logic [VALUE_W-1:0] value);
    error_cnt++;
    if (error_cnt <= MAX_PRINTED) begin
      $display("%0t ns: value %0d: %s is %0d, predicted %0d", $time, value, what, got,
               want);
    end
  endtask

  // Stimulus. Directed values first: zero, each decade boundary from both
  // sides, the largest value, and alternating bit patterns. The random part
  // then mixes uniform 16-bit values, values drawn evenly per digit count so
  // that short texts are as common as long ones, and values right next to
  // the powers of ten where the digit count changes.
  initial begin
    logic [VALUE_W-1:0] pick;
    int unsigned        len;
    int unsigned        decade_lo[1:5];
    int unsigned        decade_hi[1:5];
    decade_lo = '{0, 10, 100, 1000, 10000};
    decade_hi = '{9, 99, 999, 9999, 65535};

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    out_stall_i = 1'b0;
    burst_left  = 0;
    gap_left    = 0;
    stall_mode  = 0;
    stall_phase = 0;
    error_cnt   = 0;
    checked_cnt = 0;
    for (int k = 1; k <= 5; k++) begin
      count_seen[k] = 0;
    end

    value_q = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100, 16'd999,
                16'd1000, 16'd9999, 16'd10000, 16'd10001, 16'd65535, 16'd65534,
                16'd32768, 16'h5555, 16'hAAAA, 16'd12345, 16'd60000, 16'd40509,
                16'd90, 16'd505, 16'd7007};

    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          pick = VALUE_W'($urandom);
        end
        4, 5, 6, 7: begin
          len  = $urandom_range(1, 5);
          pick = VALUE_W'($urandom_range(decade_hi[len], decade_lo[len]));
        end
        default: begin
          len = $urandom_range(2, 5);
          pick = VALUE_W'(int'(decade_lo[len]) + $urandom_range(2, 0) - 1);
        end
      endcase
      value_q.push_back(pick);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Everything offered and taken, then every result back, then a short
    // wait so that any stray extra output transaction is caught too.
    while (value_q.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (text_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted and checked %0d values with random input gaps and output stalls.",
             checked_cnt);
    $display("Results per digit count 1..5: %0d %0d %0d %0d %0d; mismatches: %0d",
             count_seen[1], count_seen[2], count_seen[3], count_seen[4], count_seen[5],
             error_cnt);
    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Sender. Inputs change on the falling edge. A transaction on the bus is
  // held unchanged until the rising edge that takes it; only then does the
  // next value, or a gap, follow. Bursts have random length, and the gap
  // after a burst is zero about half the time so that long unbroken
  // streams also occur.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
        value_i    <= VALUE_W'($urandom);
      end else if (value_q.size() > 0) begin
        in_valid_i <= 1'b1;
        value_i    <= value_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver. A new stall mode is drawn whenever stall_phase reaches a multiple
  // of the redraw period: no stalls at all, light random stalls, a fixed stall
  // pattern that lets the pipeline fill and push back on the input, or heavy stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      stall_phase++;
      if (stall_phase % 50 == 0) begin
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ((stall_phase % 8) < 3);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Monitor. Sampling at the rising edge sees the values that settled
  // during the cycle, before the block's registers move. An accepted input
  // transaction adds its predicted text to the queue; an accepted output
  // transaction is compared field by field with the oldest prediction.
  always @(posedge clk_i) begin
    decimal_text_t want;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      text_q.push_back(decimal_text(value_i));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (text_q.size() == 0) begin
        report_mismatch("unexpected output transaction, count", int'(digit_count_o), 0,
                        '0);
      end else begin
        want = text_q.pop_front();
        checked_cnt++;
        if (want.count >= 1 && want.count <= 5) begin
          count_seen[want.count]++;
        end
        if (char_first_o !== want.text[0]) begin
          report_mismatch("char_first", int'(char_first_o), int'(want.text[0]), want.value);
        end
        if (char_second_o !== want.text[1]) begin
          report_mismatch("char_second", int'(char_second_o), int'(want.text[1]),
                          want.value);
        end
        if (char_third_o !== want.text[2]) begin
          report_mismatch("char_third", int'(char_third_o), int'(want.text[2]), want.value);
        end
        if (char_fourth_o !== want.text[3]) begin
          report_mismatch("char_fourth", int'(char_fourth_o), int'(want.text[3]),
                          want.value);
        end
        if (char_fifth_o !== want.text[4]) begin
          report_mismatch("char_fifth", int'(char_fifth_o), int'(want.text[4]), want.value);
        end
        if (digit_count_o !== want.count) begin
          report_mismatch("digit_count", int'(digit_count_o), int'(want.count), want.value);
        end
      end
    end
  end

  // A correct run finishes well within this bound.
  initial begin
    #2_000_000;
    $display("Run did not finish in time: %0d values still queued, %0d results pending.",
             value_q.size(), text_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
